FILE: rtl/itp_pkg.sv
// ----------------------------------------------------------------------------
// itp_pkg: shared definitions for the integer text parser
// parse phases, register indexes, character codes and sizes
// ----------------------------------------------------------------------------
package itp_pkg;

   // width of the saturating consumed-character counter
   localparam int COUNT_WIDTH = 16;

   localparam int CHAR_WIDTH  = 8;
   localparam int VALUE_WIDTH = 64;
   localparam int BASE_WIDTH  = 6;
   localparam int CNT_PORT_W  = 16;
   localparam int IDX_WIDTH   = 2;

   // configuration register indexes
   localparam logic [IDX_WIDTH-1:0] REG_BASE_SELECT = 2'd0;
   localparam logic [IDX_WIDTH-1:0] REG_SIGNED_MODE = 2'd1;
   localparam logic [IDX_WIDTH-1:0] REG_WIDE_MODE   = 2'd2;

   // characters with a meaning of their own
   localparam logic [CHAR_WIDTH-1:0] CHAR_MINUS = 8'h2D;
   localparam logic [CHAR_WIDTH-1:0] CHAR_ZERO  = 8'h30;
   localparam logic [CHAR_WIDTH-1:0] CHAR_LOW_X = 8'h78;
   localparam logic [CHAR_WIDTH-1:0] CHAR_LOW_B = 8'h62;

   // bases
   localparam logic [BASE_WIDTH-1:0] BASE_AUTO = 6'd0;
   localparam logic [BASE_WIDTH-1:0] BASE_BIN  = 6'd2;
   localparam logic [BASE_WIDTH-1:0] BASE_OCT  = 6'd8;
   localparam logic [BASE_WIDTH-1:0] BASE_DEC  = 6'd10;
   localparam logic [BASE_WIDTH-1:0] BASE_HEX  = 6'd16;
   localparam logic [BASE_WIDTH-1:0] BASE_MAX  = 6'd36;

   // digit code for a character that is no digit at all
   localparam logic [BASE_WIDTH-1:0] DIGIT_NONE = 6'd63;

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_SIGN,
      PH_PREFIX,
      PH_ZERO,
      PH_DIGITS
   } phase_type;

endpackage

FILE: rtl/integer_text_parser.sv
// ----------------------------------------------------------------------------
// integer_text_parser: streaming text to integer converter
// one character per word; optional minus, automatic 0x / 0b / 0 prefix,
// digits of bases 2 to 36, exact overflow with saturation
// ----------------------------------------------------------------------------
//
//  channel   direction  tdata                              tuser          tlast
//  req_      in         [7:0] char_code                    [0] first_char last_char
//  rsp_      out        [63:0] value, [79:64] consumed     [0] range_error -
//  csr_      in         write enable, index, data          -              -
//
//  one character per cycle sustained while the result is not stalled; a word
//  is held in the input register and its result, if any, is loaded from there
//  into the output register
//  the rate is set by the single digit step: a 64 by 6 bit multiply-add and
//  the limit compare between the input register and the result register
//  reset (synchronous, active high) clears the parse state and loads the
//  register defaults: automatic base, signed, 32-bit results
//  a stalled result holds the input register; req_tready stays high while
//  the held word can still move on in the same cycle
//
module integer_text_parser (
   input  logic        clock,
   input  logic        reset,

   // input characters
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] char_code
   input  logic [0:0]  req_tuser,   // [0] first_char
   input  logic        req_tlast,   // last_char

   // parsed numbers
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [79:0] rsp_tdata,   // [63:0] value, [79:64] consumed_count
   output logic [0:0]  rsp_tuser,   // [0] range_error

   // register writes
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [5:0]  csr_wdata
);

   localparam int CW = itp_pkg::COUNT_WIDTH;
   localparam int VW = itp_pkg::VALUE_WIDTH;
   localparam int BW = itp_pkg::BASE_WIDTH;
   localparam int PW = VW + BW + 1;   // product plus digit, never wraps

   // configuration registers
   logic [BW-1:0] base_select_ff;
   logic          signed_mode_ff;
   logic          wide_mode_ff;

   // input register
   logic                          in_valid_ff;
   logic [itp_pkg::CHAR_WIDTH-1:0] in_char_ff;
   logic                          in_first_ff;
   logic                          in_last_ff;

   // parse state
   itp_pkg::phase_type phase_ff, phase_in;
   logic [VW-1:0]      acc_ff, acc_in;
   logic [BW-1:0]      base_ff, base_in;
   logic               neg_ff, neg_in;
   logic [CW-1:0]      cnt_ff, cnt_in;

   // result register
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [VW-1:0]                 rsp_value_ff, rsp_value_in;
   logic                          rsp_range_ff, rsp_range_in;
   logic [itp_pkg::CNT_PORT_W-1:0] rsp_count_ff, rsp_count_in;

   logic do_emit;
   logic proc_fire;

   // digit value of a character, DIGIT_NONE for anything else
   function automatic logic [BW-1:0] digit_of(input logic [7:0] c);
      logic [BW-1:0] d;
      d = itp_pkg::DIGIT_NONE;
      if (c >= 8'h30 && c <= 8'h39) begin
         d = BW'(c - 8'h30);
      end else if (c >= 8'h41 && c <= 8'h5A) begin
         d = BW'(c - 8'h41 + 8'd10);
      end else if (c >= 8'h61 && c <= 8'h7A) begin
         d = BW'(c - 8'h61 + 8'd10);
      end
      return d;
   endfunction

   // --------------------------------------------------------------------------
   // handshake: the held word moves on when the result slot is free or freeing
   // --------------------------------------------------------------------------
   always_comb begin
      proc_fire  = in_valid_ff && (!rsp_valid_ff || rsp_tready);
      req_tready = !in_valid_ff || proc_fire;
   end

   // --------------------------------------------------------------------------
   // next state: one character step on the held word
   // --------------------------------------------------------------------------
   always_comb begin
      logic          taken;
      logic          stop;
      logic          ovf;
      logic [BW-1:0] b;
      logic [BW-1:0] d;
      logic [VW-1:0] mask;
      logic [VW-1:0] lim;
      logic [VW-1:0] mag;
      logic [PW-1:0] prod;

      phase_in = phase_ff;
      acc_in   = acc_ff;
      base_in  = base_ff;
      neg_in   = neg_ff;
      cnt_in   = cnt_ff;
      taken    = 1'b0;
      stop     = 1'b0;
      ovf      = 1'b0;
      do_emit  = 1'b0;
      b        = itp_pkg::BASE_DEC;
      d        = itp_pkg::DIGIT_NONE;
      prod     = '0;

      mask = wide_mode_ff ? {VW{1'b1}} : {{(VW/2){1'b0}}, {(VW/2){1'b1}}};

      // a first character restarts, dropping any unfinished number
      if (in_first_ff) begin
         acc_in = '0;
         neg_in = 1'b0;
         cnt_in = '0;
         if (base_select_ff == itp_pkg::BASE_AUTO) begin
            base_in = itp_pkg::BASE_AUTO;
         end else if (base_select_ff >= itp_pkg::BASE_BIN &&
                      base_select_ff <= itp_pkg::BASE_MAX) begin
            base_in = base_select_ff;
         end else begin
            base_in = itp_pkg::BASE_DEC;
         end
         phase_in = itp_pkg::PH_SIGN;
      end

      if (phase_in != itp_pkg::PH_IDLE) begin
         // optional minus
         if (phase_in == itp_pkg::PH_SIGN) begin
            phase_in = itp_pkg::PH_PREFIX;
            if (signed_mode_ff && in_char_ff == itp_pkg::CHAR_MINUS) begin
               neg_in = 1'b1;
               if (cnt_in != '1) cnt_in = cnt_in + 1'b1;
               taken = 1'b1;
            end
         end
         // leading zero opens a prefix under automatic base
         if (!taken && phase_in == itp_pkg::PH_PREFIX) begin
            if (base_in == itp_pkg::BASE_AUTO && in_char_ff == itp_pkg::CHAR_ZERO) begin
               if (cnt_in != '1) cnt_in = cnt_in + 1'b1;
               phase_in = itp_pkg::PH_ZERO;
               taken = 1'b1;
            end else begin
               if (base_in == itp_pkg::BASE_AUTO) base_in = itp_pkg::BASE_DEC;
               phase_in = itp_pkg::PH_DIGITS;
            end
         end
         // character after the leading zero
         if (!taken && phase_in == itp_pkg::PH_ZERO) begin
            phase_in = itp_pkg::PH_DIGITS;
            if (in_char_ff == itp_pkg::CHAR_LOW_X) begin
               base_in = itp_pkg::BASE_HEX;
               if (cnt_in != '1) cnt_in = cnt_in + 1'b1;
               taken = 1'b1;
            end else if (in_char_ff == itp_pkg::CHAR_LOW_B) begin
               base_in = itp_pkg::BASE_BIN;
               if (cnt_in != '1) cnt_in = cnt_in + 1'b1;
               taken = 1'b1;
            end else begin
               base_in = itp_pkg::BASE_OCT;
            end
         end
         // digit step: acc * base + digit, overflow when above the limit
         if (!taken && phase_in == itp_pkg::PH_DIGITS) begin
            b = (base_in >= itp_pkg::BASE_BIN && base_in <= itp_pkg::BASE_MAX) ?
                base_in : itp_pkg::BASE_DEC;
            d = digit_of(in_char_ff);
            if (d >= b) begin
               do_emit = 1'b1;
               stop    = 1'b1;
            end else begin
               lim = signed_mode_ff ? ((mask >> 1) + VW'(neg_in)) : mask;
               if (cnt_in != '1) cnt_in = cnt_in + 1'b1;
               prod = PW'(acc_in) * PW'(b) + PW'(d);
               if (acc_in > lim || prod > PW'(lim)) begin
                  ovf     = 1'b1;
                  do_emit = 1'b1;
                  stop    = 1'b1;
               end else begin
                  acc_in = prod[VW-1:0];
               end
            end
         end
         if (!stop && in_last_ff) do_emit = 1'b1;
      end

      // result: limit rechecked against the current modes
      lim = signed_mode_ff ? ((mask >> 1) + VW'(neg_in)) : mask;
      mag = acc_in;
      if (mag > lim) ovf = 1'b1;
      if (ovf) mag = lim;
      rsp_value_in = neg_in ? ((VW'(0) - mag) & mask) : (mag & mask);
      rsp_range_in = ovf;
      rsp_count_in = itp_pkg::CNT_PORT_W'(32'(cnt_in));
      if (do_emit) phase_in = itp_pkg::PH_IDLE;

      // result slot
      if (proc_fire) begin
         rsp_valid_in = do_emit;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // --------------------------------------------------------------------------
   // registers
   // --------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         base_select_ff <= itp_pkg::BASE_AUTO;
         signed_mode_ff <= 1'b1;
         wide_mode_ff   <= 1'b0;
      end else if (csr_we) begin
         case (csr_index)
            itp_pkg::REG_BASE_SELECT: base_select_ff <= csr_wdata;
            itp_pkg::REG_SIGNED_MODE: signed_mode_ff <= csr_wdata[0];
            itp_pkg::REG_WIDE_MODE:   wide_mode_ff   <= csr_wdata[0];
            default: ;   // no register there
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   // input payload, loaded on accept
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_char_ff  <= req_tdata;
         in_first_ff <= req_tuser[0];
         in_last_ff  <= req_tlast;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= itp_pkg::PH_IDLE;
         acc_ff   <= '0;
         base_ff  <= itp_pkg::BASE_DEC;
         neg_ff   <= 1'b0;
         cnt_ff   <= '0;
      end else if (proc_fire) begin
         phase_ff <= phase_in;
         acc_ff   <= acc_in;
         base_ff  <= base_in;
         neg_ff   <= neg_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // result payload, loaded when a result is produced
   always_ff @(posedge clock) begin
      if (proc_fire && do_emit) begin
         rsp_value_ff <= rsp_value_in;
         rsp_range_ff <= rsp_range_in;
         rsp_count_ff <= rsp_count_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_count_ff, rsp_value_ff};
   assign rsp_tuser  = rsp_range_ff;

endmodule
